>>> design/spq_pkg.sv
package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 20;
  localparam int KEY_BITS    = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // What every cell of the row does on a clock edge.
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } act_t;

  typedef struct packed {
    act_t act;
    logic pop;
  } row_ctrl_t;

endpackage

>>> design/spq_cmd_if.sv
interface spq_cmd_if #(
  parameter int ID_BITS  = spq_pkg::ID_BITS,
  parameter int KEY_BITS = spq_pkg::KEY_BITS
);
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [ID_BITS-1:0]  entry_id;
  logic [KEY_BITS-1:0] entry_key;

  modport source (output valid, operation, entry_id, entry_key, input ready);
  modport sink   (input valid, operation, entry_id, entry_key, output ready);
endinterface

>>> design/spq_res_if.sv
interface spq_res_if #(
  parameter int ID_BITS  = spq_pkg::ID_BITS,
  parameter int KEY_BITS = spq_pkg::KEY_BITS,
  parameter int CNT_BITS = $clog2(spq_pkg::QUEUE_DEPTH + 1)
);
  logic                valid;
  logic                ready;
  logic [ID_BITS-1:0]  out_id;
  logic [KEY_BITS-1:0] out_key;
  logic [1:0]          status;
  logic [CNT_BITS-1:0] occupancy;

  modport source (output valid, out_id, out_key, status, occupancy, input ready);
  modport sink   (input valid, out_id, out_key, status, occupancy, output ready);
endinterface

>>> design/sorted_priority_queue_update.sv
// Channel  Modport  Payload
// cmd      sink     operation, entry_id, entry_key
// res      source   out_id, out_key, status, occupancy
//
// Insert, remove-minimum and unknown codes capture the word, then finish in S_EXEC,
// where the whole row of cells shifts in parallel for an insert or remove. Update
// runs the delete pass of the row in S_EXEC, ahead of the insert pass in S_INSERT.
// Reset clears the entry count and the handshake state; slot contents are not reset.
// A new command word is taken while a result still waits in the output register;
// the pass that produces the result only runs once that register is free.
module sorted_priority_queue_update #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH,
  parameter int ID_BITS     = spq_pkg::ID_BITS,
  parameter int KEY_BITS    = spq_pkg::KEY_BITS
) (
  input logic        clk,
  input logic        rst,
  spq_cmd_if.sink    cmd,
  spq_res_if.source  res
);

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_INSERT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [1:0]          cmd_op;
  logic [ID_BITS-1:0]  cmd_id;
  logic [KEY_BITS-1:0] cmd_key;
  logic [CNT_BITS-1:0] count, count_next;

  logic                res_valid;
  logic [ID_BITS-1:0]  res_id, res_id_next;
  logic [KEY_BITS-1:0] res_key, res_key_next;
  logic [1:0]          res_status, res_status_next;
  logic [CNT_BITS-1:0] res_occ;
  logic                res_load;
  logic                out_free;

  spq_pkg::row_ctrl_t  ctrl;

  logic [ID_BITS-1:0]  cell_id  [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] cell_key [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] in_front;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] take_right;

  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !res_valid || res.ready;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_row
      logic [ID_BITS-1:0]  l_id, r_id;
      logic [KEY_BITS-1:0] l_key, r_key;
      logic                l_before;

      // A pop or a match at or before this slot moves it one place toward the head.
      assign take_right[g] = ctrl.pop || (|match[g:0]);

      if (g == 0) begin : g_first
        assign l_id     = '0;
        assign l_key    = '0;
        assign l_before = 1'b0;
      end else begin : g_inner
        assign l_id     = cell_id[g-1];
        assign l_key    = cell_key[g-1];
        assign l_before = in_front[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign r_id  = '0;
        assign r_key = '0;
      end else begin : g_inner_r
        assign r_id  = cell_id[g+1];
        assign r_key = cell_key[g+1];
      end

      spq_cell #(
        .ID_BITS  (ID_BITS),
        .KEY_BITS (KEY_BITS),
        .CNT_BITS (CNT_BITS),
        .INDEX    (g)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .take_right  (take_right[g]),
        .count       (count),
        .new_id      (cmd_id),
        .new_key     (cmd_key),
        .left_id     (l_id),
        .left_key    (l_key),
        .left_before (l_before),
        .right_id    (r_id),
        .right_key   (r_key),
        .id          (cell_id[g]),
        .key         (cell_key[g]),
        .in_front    (in_front[g]),
        .match       (match[g])
      );
    end
  endgenerate

  always_comb begin
    state_next      = state;
    count_next      = count;
    ctrl.act        = spq_pkg::ACT_HOLD;
    ctrl.pop        = 1'b0;
    res_load        = 1'b0;
    res_id_next     = '0;
    res_key_next    = '0;
    res_status_next = spq_pkg::STATUS_DONE;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_op == spq_pkg::OP_UPDATE) begin
          ctrl.act = spq_pkg::ACT_DELETE;
          if (|match) begin
            count_next = count - 1'b1;
          end
          state_next = S_INSERT;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          case (cmd_op)
            spq_pkg::OP_INSERT: begin
              if (count >= FULL_COUNT) begin
                res_status_next = spq_pkg::STATUS_FULL;
              end else begin
                ctrl.act   = spq_pkg::ACT_INSERT;
                count_next = count + 1'b1;
              end
            end
            spq_pkg::OP_REMOVE: begin
              if (count == '0) begin
                res_status_next = spq_pkg::STATUS_EMPTY;
              end else begin
                ctrl.act     = spq_pkg::ACT_DELETE;
                ctrl.pop     = 1'b1;
                res_id_next  = cell_id[0];
                res_key_next = cell_key[0];
                count_next   = count - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INSERT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (count >= FULL_COUNT) begin
            res_status_next = spq_pkg::STATUS_FULL;
          end else begin
            ctrl.act   = spq_pkg::ACT_INSERT;
            count_next = count + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_op  <= cmd.operation;
      cmd_id  <= cmd.entry_id;
      cmd_key <= cmd.entry_key;
    end
    if (res_load) begin
      res_id     <= res_id_next;
      res_key    <= res_key_next;
      res_status <= res_status_next;
      res_occ    <= count_next;
    end
  end

  assign res.valid     = res_valid;
  assign res.out_id    = res_id;
  assign res.out_key   = res_key;
  assign res.status    = res_status;
  assign res.occupancy = res_occ;

endmodule

>>> design/spq_cell.sv
module spq_cell #(
  parameter int ID_BITS  = spq_pkg::ID_BITS,
  parameter int KEY_BITS = spq_pkg::KEY_BITS,
  parameter int CNT_BITS = $clog2(spq_pkg::QUEUE_DEPTH + 1),
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  spq_pkg::row_ctrl_t  ctrl,
  input  logic                take_right,
  input  logic [CNT_BITS-1:0] count,
  input  logic [ID_BITS-1:0]  new_id,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [ID_BITS-1:0]  left_id,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                left_before,
  input  logic [ID_BITS-1:0]  right_id,
  input  logic [KEY_BITS-1:0] right_key,
  output logic [ID_BITS-1:0]  id,
  output logic [KEY_BITS-1:0] key,
  output logic                in_front,
  output logic                match
);

  localparam logic [CNT_BITS-1:0] SLOT = CNT_BITS'(INDEX);

  logic occupied;
  logic key_after;

  assign occupied = SLOT < count;

  // The head keeps its place against an equal key; every other slot yields to it.
  generate
    if (INDEX == 0) begin : g_head
      assign key_after = key > new_key;
    end else begin : g_body
      assign key_after = key >= new_key;
    end
  endgenerate

  assign in_front = !occupied || key_after;
  assign match    = occupied && (id == new_id);

  always_ff @(posedge clk) begin
    case (ctrl.act)
      spq_pkg::ACT_INSERT: begin
        if (in_front) begin
          if (left_before) begin
            id  <= left_id;
            key <= left_key;
          end else begin
            id  <= new_id;
            key <= new_key;
          end
        end
      end
      spq_pkg::ACT_DELETE: begin
        if (take_right) begin
          id  <= right_id;
          key <= right_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
